/* rtl/core/nau_pkg.sv */
package nau_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 12;
  localparam int TABLE_DEPTH = 256;
  localparam int TQ          = 30;

  localparam int TD_LOG  = $clog2(TABLE_DEPTH);
  localparam int IDX_W   = TD_LOG + 1;
  localparam int U_W     = DATA_WIDTH + 1;
  localparam int POS_W   = U_W + TD_LOG - 4;
  localparam int Q_W     = TQ + 1;
  localparam int PROD1_W = Q_W + FRAC_BITS;
  localparam int PROD2_W = 2 * Q_W;
  localparam int PROD3_W = DATA_WIDTH + Q_W + 1;
  localparam int RW      = DATA_WIDTH + 2;
  localparam int LK_W    = DATA_WIDTH + FRAC_BITS + 1;
  localparam int FWD_W   = Q_W - (TQ - FRAC_BITS) + 1;
  localparam int MODE_W  = 3;

  localparam int LEAKY_SLOPE = ((1 << FRAC_BITS) + 5) / 10;

  localparam logic [U_W:0]   U_LIMIT = (U_W + 1)'(64'd16 << FRAC_BITS);
  localparam logic [Q_W-1:0] Q_ONE   = Q_W'(64'd1 << TQ);

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_RELU     = 3'd0,
    MODE_SIGMOID  = 3'd1,
    MODE_IDENTITY = 3'd2,
    MODE_TANH     = 3'd3,
    MODE_LEAKY    = 3'd4
  } mode_t;

  typedef struct packed {
    logic              valid;
    logic              action;
    logic [MODE_W-1:0] mode;
    data_t             z;
    data_t             g;
  } ctx_t;

  typedef struct packed {
    ctx_t                  ctx;
    logic [Q_W-1:0]        s;
    logic signed [RW-1:0]  simple_res;
  } interp_t;

  typedef struct packed {
    logic                 valid;
    logic signed [RW-1:0] res;
  } res_t;

  typedef logic [TABLE_DEPTH:0][Q_W-1:0] rom_t;

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Samples of sigmoid(16*k/TABLE_DEPTH) in unsigned Q0.30.
  function automatic rom_t build_rom();
    rom_t               rom;
    logic [63:0]        t;
    logic [63:0]        r;
    logic [63:0]        p;
    logic [63:0]        den;
    logic signed [63:0] sum;
    t   = 64'd1 << TQ;
    sum = signed'(t);
    for (int n = 1; n < 64; n++) begin
      if (t != 64'd0) begin
        t = udiv64(t << 4, 64'(TABLE_DEPTH) * 64'(n));
        if ((n & 1) != 0) begin
          sum = sum - signed'(t);
        end else begin
          sum = sum + signed'(t);
        end
      end
    end
    r = unsigned'(sum);
    p = 64'd1 << TQ;
    for (int k = 0; k <= TABLE_DEPTH; k++) begin
      den    = (64'd1 << TQ) + p;
      rom[k] = Q_W'(udiv64((64'd1 << (2 * TQ)) + (den >> 1), den));
      p      = (p * r + (64'd1 << (TQ - 1))) >> TQ;
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  function automatic logic signed [RW-1:0] ext_res(data_t v);
    return {{(RW - DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
  endfunction

endpackage

/* rtl/core/nau_if.sv */
interface nau_in_if import nau_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  data_t z_value;
  data_t upstream_gradient;

  modport source(output valid, action, z_value, upstream_gradient, input ready);
  modport sink(input valid, action, z_value, upstream_gradient, output ready);
endinterface

interface nau_out_if import nau_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t result_value;
  logic  saturated;

  modport source(output valid, result_value, saturated, input ready);
  modport sink(input valid, result_value, saturated, output ready);
endinterface

/* rtl/core/nau_interp.sv */
module nau_interp import nau_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  ctx_t    in_ctx,
  output interp_t out_word
);

  logic [U_W-1:0]   mag;
  logic [U_W:0]     u;
  logic [POS_W-1:0] pos;
  logic             clip;
  logic [U_W-1:0]   zext;

  ctx_t                 s1_ctx;
  logic [IDX_W-1:0]     s1_idx;
  logic [FRAC_BITS-1:0] s1_w;

  logic [IDX_W-1:0] hi_idx;
  logic [Q_W-1:0]   lo;
  logic [Q_W-1:0]   hi;

  ctx_t                 s2_ctx;
  logic [Q_W-1:0]       s2_lo;
  logic [Q_W-1:0]       s2_diff;
  logic [FRAC_BITS-1:0] s2_w;

  localparam logic signed [FRAC_BITS:0] LK_CONST = (FRAC_BITS + 1)'(LEAKY_SLOPE);

  ctx_t                    s3_ctx;
  logic [Q_W-1:0]          s3_lo;
  logic [PROD1_W-1:0]      s3_prod;
  logic signed [LK_W-1:0]  s3_lk;
  data_t                   lk_sel;

  logic [PROD1_W:0]        rnd1;
  logic signed [LK_W-1:0]  lk_sum;
  logic signed [RW-1:0]    lk_res;
  logic signed [RW-1:0]    simple;
  logic                    z_neg;
  logic                    z_pos;

  ctx_t                 s4_ctx;
  logic [Q_W-1:0]       s4_s;
  logic signed [RW-1:0] s4_simple;

  always_comb begin
    zext = {in_ctx.z[DATA_WIDTH-1], in_ctx.z};
    mag  = in_ctx.z[DATA_WIDTH-1] ? (U_W'(0) - zext) : zext;
    u    = (in_ctx.mode == MODE_TANH) ? {mag, 1'b0} : {1'b0, mag};
    pos  = POS_W'(u) << (TD_LOG - 4);
    clip = u >= U_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctx.valid <= 1'b0;
    end else if (advance) begin
      s1_ctx <= in_ctx;
      s1_idx <= clip ? IDX_W'(TABLE_DEPTH) : IDX_W'(pos >> FRAC_BITS);
      s1_w   <= clip ? '0 : pos[FRAC_BITS-1:0];
    end
  end

  always_comb begin
    hi_idx = (s1_idx == IDX_W'(TABLE_DEPTH)) ? s1_idx : s1_idx + IDX_W'(1);
    lo     = SIG_ROM[s1_idx];
    hi     = SIG_ROM[hi_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctx.valid <= 1'b0;
    end else if (advance) begin
      s2_ctx  <= s1_ctx;
      s2_lo   <= lo;
      s2_diff <= hi - lo;
      s2_w    <= s1_w;
    end
  end

  assign lk_sel = s2_ctx.action ? s2_ctx.g : s2_ctx.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctx.valid <= 1'b0;
    end else if (advance) begin
      s3_ctx  <= s2_ctx;
      s3_lo   <= s2_lo;
      s3_prod <= PROD1_W'(s2_diff) * PROD1_W'(s2_w);
      s3_lk   <= LK_W'($signed(lk_sel)) * LK_W'(LK_CONST);
    end
  end

  always_comb begin
    rnd1   = (PROD1_W + 1)'(s3_prod) + (PROD1_W + 1)'(64'd1 << (FRAC_BITS - 1));
    lk_sum = s3_lk + LK_W'(64'd1 << (FRAC_BITS - 1)) - LK_W'(s3_lk[LK_W-1]);
    lk_res = RW'(lk_sum >>> FRAC_BITS);
    z_neg  = s3_ctx.z[DATA_WIDTH-1];
    z_pos  = !z_neg && (s3_ctx.z != '0);
    case (s3_ctx.mode)
      MODE_RELU: begin
        if (s3_ctx.action) begin
          simple = z_pos ? ext_res(s3_ctx.g) : '0;
        end else begin
          simple = z_pos ? ext_res(s3_ctx.z) : '0;
        end
      end
      MODE_IDENTITY: begin
        simple = s3_ctx.action ? ext_res(s3_ctx.g) : ext_res(s3_ctx.z);
      end
      MODE_LEAKY: begin
        if (s3_ctx.action) begin
          simple = z_pos ? ext_res(s3_ctx.g) : lk_res;
        end else begin
          simple = z_neg ? lk_res : ext_res(s3_ctx.z);
        end
      end
      default: begin
        simple = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctx.valid <= 1'b0;
    end else if (advance) begin
      s4_ctx    <= s3_ctx;
      s4_s      <= s3_lo + Q_W'(rnd1 >> FRAC_BITS);
      s4_simple <= simple;
    end
  end

  assign out_word = '{ctx: s4_ctx, s: s4_s, simple_res: s4_simple};

endmodule

/* rtl/core/nau_deriv.sv */
module nau_deriv import nau_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  interp_t in_word,
  output res_t    out_word
);

  logic           is_tanh;
  logic           z_neg;
  logic [Q_W:0]   t2;
  logic [Q_W-1:0] t;
  logic [Q_W-1:0] one_minus;
  logic [Q_W-1:0] fmag;
  logic           fneg;
  logic [Q_W-1:0] ma;
  logic [Q_W-1:0] mb;

  ctx_t                 s5_ctx;
  logic signed [RW-1:0] s5_simple;
  logic [Q_W-1:0]       s5_fmag;
  logic                 s5_fneg;
  logic [Q_W-1:0]       s5_ma;
  logic [Q_W-1:0]       s5_mb;

  ctx_t                 s6_ctx;
  logic signed [RW-1:0] s6_simple;
  logic [FWD_W-1:0]     s6_fwd;
  logic                 s6_fneg;
  logic [PROD2_W-1:0]   s6_prod;
  logic [Q_W:0]         frnd;

  ctx_t                 s7_ctx;
  logic signed [RW-1:0] s7_simple;
  logic signed [RW-1:0] s7_fwd;
  logic [Q_W-1:0]       s7_r2;
  logic [PROD2_W:0]     rnd2;
  logic signed [RW-1:0] fwd_s;

  ctx_t                 s8_ctx;
  logic signed [RW-1:0] s8_simple;
  logic signed [RW-1:0] s8_fwd;
  logic [Q_W-1:0]       s8_d2;

  ctx_t                      s9_ctx;
  logic signed [RW-1:0]      s9_simple;
  logic signed [RW-1:0]      s9_fwd;
  logic signed [PROD3_W-1:0] s9_prod;

  logic signed [PROD3_W-1:0] rsum;
  logic signed [RW-1:0]      back_res;
  logic signed [RW-1:0]      sel_res;

  logic                 s10_valid;
  logic signed [RW-1:0] s10_res;

  // tanh(|x|) = 2*S(2|x|) - 1, where S is never below one half.
  always_comb begin
    is_tanh   = in_word.ctx.mode == MODE_TANH;
    z_neg     = in_word.ctx.z[DATA_WIDTH-1];
    t2        = {in_word.s, 1'b0} - {1'b0, Q_ONE};
    t         = t2[Q_W-1:0];
    one_minus = Q_ONE - in_word.s;
    if (is_tanh) begin
      fmag = t;
      fneg = z_neg;
      ma   = t;
      mb   = t;
    end else begin
      fmag = z_neg ? one_minus : in_word.s;
      fneg = 1'b0;
      ma   = in_word.s;
      mb   = one_minus;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_ctx.valid <= 1'b0;
    end else if (advance) begin
      s5_ctx    <= in_word.ctx;
      s5_simple <= in_word.simple_res;
      s5_fmag   <= fmag;
      s5_fneg   <= fneg;
      s5_ma     <= ma;
      s5_mb     <= mb;
    end
  end

  assign frnd = {1'b0, s5_fmag} + (Q_W + 1)'(64'd1 << (TQ - FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_ctx.valid <= 1'b0;
    end else if (advance) begin
      s6_ctx    <= s5_ctx;
      s6_simple <= s5_simple;
      s6_fwd    <= FWD_W'(frnd >> (TQ - FRAC_BITS));
      s6_fneg   <= s5_fneg;
      s6_prod   <= PROD2_W'(s5_ma) * PROD2_W'(s5_mb);
    end
  end

  always_comb begin
    rnd2  = (PROD2_W + 1)'(s6_prod) + (PROD2_W + 1)'(64'd1 << (TQ - 1));
    fwd_s = signed'(RW'(s6_fwd));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_ctx.valid <= 1'b0;
    end else if (advance) begin
      s7_ctx    <= s6_ctx;
      s7_simple <= s6_simple;
      s7_fwd    <= s6_fneg ? -fwd_s : fwd_s;
      s7_r2     <= Q_W'(rnd2 >> TQ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_ctx.valid <= 1'b0;
    end else if (advance) begin
      s8_ctx    <= s7_ctx;
      s8_simple <= s7_simple;
      s8_fwd    <= s7_fwd;
      s8_d2     <= (s7_ctx.mode == MODE_TANH) ? (Q_ONE - s7_r2) : s7_r2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_ctx.valid <= 1'b0;
    end else if (advance) begin
      s9_ctx    <= s8_ctx;
      s9_simple <= s8_simple;
      s9_fwd    <= s8_fwd;
      s9_prod   <= PROD3_W'($signed(s8_ctx.g)) * PROD3_W'($signed({1'b0, s8_d2}));
    end
  end

  // Adding one less than half for negative values rounds ties away from zero.
  always_comb begin
    rsum     = s9_prod + PROD3_W'(64'd1 << (TQ - 1)) - PROD3_W'(s9_prod[PROD3_W-1]);
    back_res = RW'(rsum >>> TQ);
    if ((s9_ctx.mode == MODE_SIGMOID) || (s9_ctx.mode == MODE_TANH)) begin
      sel_res = s9_ctx.action ? back_res : s9_fwd;
    end else begin
      sel_res = s9_simple;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else if (advance) begin
      s10_valid <= s9_ctx.valid;
      s10_res   <= sel_res;
    end
  end

  assign out_word = '{valid: s10_valid, res: s10_res};

endmodule

/* rtl/core/neural_activation_unit.sv */
// Elementwise activation unit for signed Q4.12 words. The mode register selects ReLU, sigmoid,
// identity, tanh or leaky ReLU (slope 0.1); a forward word returns f(z), a backward word returns
// upstream_gradient * f'(z). The pipeline takes one word per clock while the result side is not
// stalled; the depth is set by the chain of sigmoid table lookup, interpolation
// multiply, derivative square and gradient multiply, each behind its own register. Sigmoid and
// tanh share one 257-entry constant sigmoid table, read at two neighboring points per word. A
// stall at the result side holds the whole pipeline. Write the mode only while no word is in
// flight. Results outside the 16-bit range are clipped and flagged.
module neural_activation_unit import nau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata,
  nau_in_if.sink            operand,
  nau_out_if.source         result
);

  localparam logic signed [RW-1:0] RES_MAX = RW'((2 ** (DATA_WIDTH - 1)) - 1);
  localparam logic signed [RW-1:0] RES_MIN = RW'(-(2 ** (DATA_WIDTH - 1)));

  logic [MODE_W-1:0] mode;
  logic              advance;
  ctx_t              in_ctx;
  interp_t           interp_word;
  res_t              deriv_word;

  logic                 out_valid;
  logic signed [RW-1:0] out_res;
  logic                 out_sat;
  logic signed [RW-1:0] clamped;
  logic                 clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RELU;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  assign advance       = !out_valid || result.ready;
  assign operand.ready = advance;

  assign in_ctx = '{
    valid:  operand.valid,
    action: operand.action,
    mode:   mode,
    z:      operand.z_value,
    g:      operand.upstream_gradient
  };

  nau_interp u_interp (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_ctx   (in_ctx),
    .out_word (interp_word)
  );

  nau_deriv u_deriv (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_word  (interp_word),
    .out_word (deriv_word)
  );

  always_comb begin
    if ($signed(deriv_word.res) > RES_MAX) begin
      clamped = RES_MAX;
      clip    = 1'b1;
    end else if ($signed(deriv_word.res) < RES_MIN) begin
      clamped = RES_MIN;
      clip    = 1'b1;
    end else begin
      clamped = deriv_word.res;
      clip    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= deriv_word.valid;
      out_res   <= clamped;
      out_sat   <= clip;
    end
  end

  assign result.valid        = out_valid;
  assign result.result_value = out_res[DATA_WIDTH-1:0];
  assign result.saturated    = out_sat;

endmodule

/* test/tb_neural_activation_unit.sv */
`timescale 1ns / 1ps

module tb_neural_activation_unit;
  import nau_pkg::*;

  localparam logic ACT_FORWARD  = 1'b0;
  localparam logic ACT_BACKWARD = 1'b1;

  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_MID   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  localparam data_t Z_MIN = 16'sh8000;
  localparam data_t Z_MAX = 16'sh7fff;

  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES        = 12;
  localparam int PHASE_WORDS   = 152;

  class activation_scoreboard;
    typedef struct {
      data_t value;
      logic  clipped;
    } outcome_t;

    longint unsigned   sig_table [TABLE_DEPTH+1];
    logic [MODE_W-1:0] mode;
    outcome_t          pending [$];
    int                failures;
    int                checked;
    int                backward_words;
    int                clipped_results;

    function new();
      longint unsigned term;
      longint unsigned ratio;
      longint unsigned p;
      longint unsigned den;
      longint          sum;
      mode            = MODE_RELU;
      failures        = 0;
      checked         = 0;
      backward_words  = 0;
      clipped_results = 0;
      term = 64'd1 << TQ;
      sum  = longint'(term);
      for (int n = 1; n < 64 && term != 0; n++) begin
        term = term * 16 / (TABLE_DEPTH * n);
        if (n % 2 != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      ratio = sum;
      p     = 64'd1 << TQ;
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
        den          = (64'd1 << TQ) + p;
        sig_table[k] = ((64'd1 << (2 * TQ)) + den / 2) / den;
        p            = (p * ratio + (64'd1 << (TQ - 1))) >> TQ;
      end
    endfunction

    // Rounds to nearest with ties away from zero.
    function longint round_shift(longint v, int sh);
      longint unsigned m;
      longint unsigned q;
      m = v < 0 ? -v : v;
      q = (m + (64'd1 << (sh - 1))) >> sh;
      return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned magnitude(longint x);
      return x < 0 ? -x : x;
    endfunction

    function longint interp(longint unsigned u);
      longint unsigned pos;
      longint unsigned idx;
      longint unsigned w;
      longint          lo;
      longint          hi;
      if (u >= (64'd16 << FRAC_BITS)) return longint'(sig_table[TABLE_DEPTH]);
      pos = u * TABLE_DEPTH / 16;
      idx = pos >> FRAC_BITS;
      w   = pos & ((64'd1 << FRAC_BITS) - 1);
      if (idx >= TABLE_DEPTH) return longint'(sig_table[TABLE_DEPTH]);
      lo = longint'(sig_table[idx]);
      hi = longint'(sig_table[idx + 1]);
      return lo + round_shift((hi - lo) * longint'(w), FRAC_BITS);
    endfunction

    function longint sigmoid_q30(longint x);
      longint s;
      s = interp(magnitude(x));
      return x >= 0 ? s : (longint'(1) << TQ) - s;
    endfunction

    function longint tanh_q30(longint x);
      longint t;
      t = 2 * interp(2 * magnitude(x)) - (longint'(1) << TQ);
      return x >= 0 ? t : -t;
    endfunction

    function outcome_t predict(logic act, data_t z, data_t g);
      outcome_t o;
      longint   zv;
      longint   gv;
      longint   d;
      longint   res;
      longint   lk;
      longint   top;
      longint   bot;
      logic     back;
      zv   = z;
      gv   = g;
      back = (act == ACT_BACKWARD);
      lk   = ((longint'(1) << FRAC_BITS) + 5) / 10;
      top  = (longint'(1) << (DATA_WIDTH - 1)) - 1;
      bot  = -(longint'(1) << (DATA_WIDTH - 1));
      res  = 0;
      case (mode)
        MODE_RELU: begin
          if (zv > 0) res = back ? gv : zv;
        end
        MODE_SIGMOID: begin
          d = sigmoid_q30(zv);
          if (back) begin
            d   = round_shift(d * ((longint'(1) << TQ) - d), TQ);
            res = round_shift(gv * d, TQ);
          end else begin
            res = round_shift(d, TQ - FRAC_BITS);
          end
        end
        MODE_IDENTITY: begin
          res = back ? gv : zv;
        end
        MODE_TANH: begin
          d = tanh_q30(zv);
          if (back) begin
            d   = (longint'(1) << TQ) - round_shift(d * d, TQ);
            res = round_shift(gv * d, TQ);
          end else begin
            res = round_shift(d, TQ - FRAC_BITS);
          end
        end
        MODE_LEAKY: begin
          if (back) begin
            res = zv > 0 ? gv : round_shift(gv * lk, FRAC_BITS);
          end else begin
            res = zv >= 0 ? zv : round_shift(zv * lk, FRAC_BITS);
          end
        end
        default: begin
          res = 0;
        end
      endcase
      o.clipped = 1'b0;
      if (res > top) begin
        res       = top;
        o.clipped = 1'b1;
      end
      if (res < bot) begin
        res       = bot;
        o.clipped = 1'b1;
      end
      o.value = data_t'(res);
      return o;
    endfunction

    function void note_operand(logic act, data_t z, data_t g);
      if (act == ACT_BACKWARD) backward_words++;
      pending.push_back(predict(act, z, g));
    endfunction

    function void check_result(data_t value, logic clipped);
      outcome_t want;
      if (pending.size() == 0) begin
        failures++;
        $error("result word with no expectation waiting: result_value %0d", value);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.clipped) clipped_results++;
      if (value !== want.value) begin
        failures++;
        $error("result_value: expected %0d, got %0d", want.value, value);
      end
      if (clipped !== want.clipped) begin
        failures++;
        $error("saturated: expected %0b, got %0b", want.clipped, clipped);
      end
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;
  logic              steady;
  int                mode_writes;

  activation_scoreboard board;

  nau_in_if  operand_bus ();
  nau_out_if result_bus ();

  neural_activation_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .operand   (operand_bus),
    .result    (result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (operand_bus.valid && operand_bus.ready) begin
        board.note_operand(operand_bus.action, operand_bus.z_value,
                           operand_bus.upstream_gradient);
      end
      if (result_bus.valid && result_bus.ready) begin
        board.check_result(result_bus.result_value, result_bus.saturated);
      end
    end
  end

  initial begin
    int stall;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!(result_bus.valid && result_bus.ready)) @(posedge clk);
    end
  end

  function automatic data_t pick_value();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0:       return Z_MIN;
      1:       return Z_MAX;
      2:       return data_t'(0);
      3:       return data_t'(1);
      4:       return data_t'(-1);
      5, 6, 7: return data_t'(int'($urandom_range(0, 1024)) - 512);
      default: return data_t'($urandom());
    endcase
  endfunction

  task automatic send_word(logic act, data_t z, data_t g);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      operand_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operand_bus.valid             <= 1'b1;
    operand_bus.action            <= act;
    operand_bus.z_value           <= z;
    operand_bus.upstream_gradient <= g;
    @(posedge clk);
    while (!(operand_bus.valid && operand_bus.ready)) @(posedge clk);
  endtask

  task automatic wait_for_results();
    operand_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    board.mode = m;
    mode_writes++;
  endtask

  initial begin
    logic [MODE_W-1:0] phase_mode [PHASES];
    logic              act;
    data_t             z;
    data_t             g;

    board       = new();
    mode_writes = 0;
    steady      = 1'b0;
    rst                           <= 1'b1;
    cfg_we                        <= 1'b0;
    cfg_wdata                     <= MODE_RELU;
    operand_bus.valid             <= 1'b0;
    operand_bus.action            <= ACT_FORWARD;
    operand_bus.z_value           <= '0;
    operand_bus.upstream_gradient <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The mode register is still at its reset value here.
    send_word(ACT_FORWARD, Z_MAX, data_t'(0));
    send_word(ACT_FORWARD, Z_MIN, data_t'(0));
    send_word(ACT_BACKWARD, data_t'(1), Z_MIN);
    send_word(ACT_BACKWARD, data_t'(0), Z_MAX);
    write_mode(MODE_SIGMOID);
    send_word(ACT_FORWARD, Z_MIN, Z_MAX);
    send_word(ACT_FORWARD, data_t'(0), Z_MIN);
    send_word(ACT_BACKWARD, data_t'(0), Z_MAX);
    send_word(ACT_BACKWARD, Z_MAX, Z_MIN);
    write_mode(MODE_TANH);
    send_word(ACT_FORWARD, Z_MIN, data_t'(0));
    send_word(ACT_FORWARD, Z_MAX, data_t'(0));
    send_word(ACT_BACKWARD, data_t'(0), Z_MIN);
    send_word(ACT_BACKWARD, data_t'(-1), Z_MAX);
    write_mode(MODE_LEAKY);
    send_word(ACT_FORWARD, data_t'(0), data_t'(0));
    send_word(ACT_FORWARD, Z_MIN, data_t'(0));
    send_word(ACT_BACKWARD, data_t'(0), Z_MIN);
    send_word(ACT_BACKWARD, data_t'(1), Z_MAX);
    write_mode(MODE_IDENTITY);
    send_word(ACT_FORWARD, Z_MIN, Z_MAX);
    send_word(ACT_BACKWARD, Z_MAX, Z_MIN);
    write_mode(MODE_UNUSED_LAST);
    send_word(ACT_FORWARD, Z_MAX, data_t'(1));
    send_word(ACT_BACKWARD, Z_MIN, Z_MIN);

    phase_mode[0] = MODE_SIGMOID;
    phase_mode[1] = MODE_TANH;
    phase_mode[2] = MODE_LEAKY;
    phase_mode[3] = MODE_IDENTITY;
    phase_mode[4] = MODE_UNUSED_FIRST;
    phase_mode[5] = MODE_UNUSED_MID;
    phase_mode[6] = MODE_RELU;
    phase_mode[7] = MODE_UNUSED_LAST;
    for (int p = 8; p < PHASES; p++) phase_mode[p] = MODE_W'($urandom_range(0, 7));

    for (int p = 0; p < PHASES; p++) begin
      write_mode(phase_mode[p]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        if (k == PHASE_WORDS / 2 && (p == 0 || $urandom_range(0, 1) == 1)) begin
          wait_for_results();
        end
        act = 1'($urandom_range(0, 1));
        z   = pick_value();
        g   = $urandom_range(0, 1) ? pick_value() : data_t'($urandom());
        send_word(act, z, g);
      end
    end
    steady = 1'b0;

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d results checked over %0d mode writes (all eight codes),",
             board.checked, mode_writes);
    $display("Summary: %0d backward words, %0d clipped results expected.",
             board.backward_words, board.clipped_results);
    if (board.failures == 0 && board.pending_count() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/nau_pkg.sv
rtl/core/nau_if.sv
rtl/core/nau_interp.sv
rtl/core/nau_deriv.sv
rtl/core/neural_activation_unit.sv
test/tb_neural_activation_unit.sv
